// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker
// clk and rst are taken from the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mroq_pkg.sv =====
package mroq_pkg;

  // item modes
  localparam logic [1:0] MODE_POST   = 2'd0;
  localparam logic [1:0] MODE_SERIAL = 2'd1;
  localparam logic [1:0] MODE_USB    = 2'd2;

  // usb midi cable used for every packet
  localparam logic [3:0] CABLE_NUMBER = 4'd0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic       usb_enable;
  } evt_t;

  typedef struct packed {
    logic       serial_valid;
    logic [7:0] serial_byte;
    logic       usb_valid;
    logic [3:0] code_index;
    logic [3:0] cable_number;
    logic [7:0] packet_status;
    logic [7:0] packet_data_one;
    logic [7:0] packet_data_two;
  } res_t;

endpackage

// ===== rtl/mroq_evt_if.sv =====
interface mroq_evt_if;
  logic              valid;
  logic              ready;
  mroq_pkg::evt_t    payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/mroq_res_if.sv =====
interface mroq_res_if;
  logic              valid;
  logic              ready;
  mroq_pkg::res_t    payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/midi_out_running_status_queue.sv =====
// post item: states S_D1 and S_D2 follow the accept, the serial ring takes one byte per cycle
// tick item: the ring read is registered at the accept, and S_OUT loads the result
// one item at a time: a new item is accepted only in S_IDLE, once the last result is loaded
// reset clears indices, last status and the output valid flag; ring contents are not
// cleared and need no clearing pass, since only written entries are ever used
module midi_out_running_status_queue #(
  parameter int SERIAL_DEPTH = 32,
  parameter int USB_DEPTH    = 8
) (
  input  logic           clk,
  input  logic           rst,
  mroq_evt_if.sink       evt,
  mroq_res_if.source     res
);

  localparam int SAW = $clog2(SERIAL_DEPTH);
  localparam int UAW = $clog2(USB_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_D1, S_D2, S_OUT} state_t;

  state_t         state;
  logic [SAW-1:0] srd;
  logic [SAW-1:0] swr;
  logic [UAW-1:0] urd;
  logic [UAW-1:0] uwr;
  logic [7:0]     last_status;
  logic [1:0]     op;
  logic           hit;
  logic [7:0]     d1;
  logic [7:0]     d2;

  logic           accept;
  logic           out_load;
  logic           s_we;
  logic [7:0]     s_wdata;
  logic           s_re;
  logic [7:0]     s_rdata;
  logic           u_we;
  logic           u_re;
  logic [23:0]    u_rdata;
  mroq_pkg::res_t res_next;

  function automatic logic [SAW-1:0] s_inc(input logic [SAW-1:0] i);
    return (i == SAW'(SERIAL_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [UAW-1:0] u_inc(input logic [UAW-1:0] i);
    return (i == UAW'(USB_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign evt.ready = (state == S_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign out_load  = ((state == S_D2) || (state == S_OUT)) && (!res.valid || res.ready);

  // ring port control
  always_comb begin
    s_we    = 1'b0;
    s_wdata = d1;
    u_we    = 1'b0;
    if (accept && (evt.payload.mode == mroq_pkg::MODE_POST)) begin
      u_we    = evt.payload.usb_enable;
      s_we    = (evt.payload.status_byte != last_status);
      s_wdata = evt.payload.status_byte;
    end
    if (state == S_D1) begin
      s_we    = 1'b1;
      s_wdata = d1;
    end
    if (state == S_D2) begin
      s_we    = 1'b1;
      s_wdata = d2;
    end
    s_re = accept && (evt.payload.mode == mroq_pkg::MODE_SERIAL);
    u_re = accept && (evt.payload.mode == mroq_pkg::MODE_USB);
  end

  mroq_ram #(.WIDTH(8), .DEPTH(SERIAL_DEPTH)) u_serial_ring (
    .clk   (clk),
    .we    (s_we),
    .waddr (swr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (srd),
    .rdata (s_rdata)
  );

  mroq_ram #(.WIDTH(24), .DEPTH(USB_DEPTH)) u_usb_ring (
    .clk   (clk),
    .we    (u_we),
    .waddr (uwr),
    .wdata ({evt.payload.status_byte, evt.payload.data_one, evt.payload.data_two}),
    .re    (u_re),
    .raddr (urd),
    .rdata (u_rdata)
  );

  // result assembly from the latched op and ring read data
  always_comb begin
    res_next              = '0;
    res_next.cable_number = mroq_pkg::CABLE_NUMBER;
    case (op)
      mroq_pkg::MODE_SERIAL: begin
        if (hit) begin
          res_next.serial_valid = 1'b1;
          res_next.serial_byte  = s_rdata;
        end
      end
      mroq_pkg::MODE_USB: begin
        if (hit) begin
          res_next.usb_valid       = 1'b1;
          res_next.code_index      = u_rdata[23:20];
          res_next.packet_status   = u_rdata[23:16];
          res_next.packet_data_one = u_rdata[15:8];
          res_next.packet_data_two = u_rdata[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, indices and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      srd         <= '0;
      swr         <= '0;
      urd         <= '0;
      uwr         <= '0;
      last_status <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (out_load) begin
        res.valid   <= 1'b1;
        res.payload <= res_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= evt.payload.mode;
            d1 <= evt.payload.data_one;
            d2 <= evt.payload.data_two;
            case (evt.payload.mode)
              mroq_pkg::MODE_POST: begin
                if (evt.payload.usb_enable) begin
                  uwr <= u_inc(uwr);
                end
                if (evt.payload.status_byte != last_status) begin
                  last_status <= evt.payload.status_byte;
                  swr         <= s_inc(swr);
                end
                state <= S_D1;
              end
              mroq_pkg::MODE_SERIAL: begin
                hit <= (srd != swr);
                if (srd != swr) begin
                  srd <= s_inc(srd);
                end
                state <= S_OUT;
              end
              mroq_pkg::MODE_USB: begin
                hit <= (urd != uwr);
                if (urd != uwr) begin
                  urd <= u_inc(urd);
                end
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_D1: begin
          swr   <= s_inc(swr);
          state <= S_D2;
        end
        S_D2: begin
          swr   <= s_inc(swr);
          state <= out_load ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mroq_ram.sv =====
module mroq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mroq_checker.sv =====
`include "assert_macros.svh"

module mroq_checker (
  input logic           clk,
  input logic           rst,
  input logic           evt_valid,
  input logic           evt_ready,
  input logic           res_valid,
  input logic           res_ready,
  input mroq_pkg::res_t res_payload
);

  // a waiting result holds until taken
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload), "result changed while stalled")

  // one item in flight: no accept right after an accept
  `ASSERT_NEXT(a_one_item, evt_valid && evt_ready, !evt_ready, "item accepted while busy")

  // a result pops from at most one ring
  `ASSERT_NOW(a_one_pop, res_valid, !(res_payload.serial_valid && res_payload.usb_valid), "two pops in one item")

  // packet code index follows the status nibble, cable fixed
  `ASSERT_NOW(a_code_index, res_valid, (res_payload.code_index == res_payload.packet_status[7:4]) && (res_payload.cable_number == mroq_pkg::CABLE_NUMBER), "bad packet header")

endmodule

bind midi_out_running_status_queue mroq_checker u_mroq_checker (
  .clk         (clk),
  .rst         (rst),
  .evt_valid   (evt.valid),
  .evt_ready   (evt.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);
